// File: rtl/adr_pkg.sv
// adr_pkg: shared types, constants and the fcs function of the async hdlc deframer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package adr_pkg;

	localparam logic [7:0]  FLAG_BYTE   = 8'h7e;
	localparam logic [7:0]  ESC_BYTE    = 8'h7d;
	localparam logic [7:0]  QUOTE_BIT   = 8'h20;
	localparam logic [7:0]  CTL_LIMIT   = 8'h20;
	localparam logic [15:0] FCS_INIT    = 16'hffff;
	localparam logic [15:0] FCS_GOOD    = 16'hf0b8;
	localparam logic [15:0] FCS_POLY    = 16'h8408;
	localparam logic [15:0] COUNT_MAX   = 16'hffff;
	localparam int          QUEUE_DEPTH = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINK_ENABLE = 3'd0,
		REG_RX_CTL_MAP  = 3'd1,
		REG_FLOW_ENABLE = 3'd2,
		REG_STOP_CHAR   = 3'd3,
		REG_START_CHAR  = 3'd4
	} reg_idx_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_END   = 2'd1,
		KIND_STOP  = 2'd2,
		KIND_START = 2'd3
	} kind_t;

	// byte classes handed from the front to the back
	typedef enum logic [2:0] {
		OP_FLAG  = 3'd0,
		OP_ESC   = 3'd1,
		OP_STOP  = 3'd2,
		OP_START = 3'd3,
		OP_DATA  = 3'd4
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} action_t;

	// reflected crc-16, one byte
	function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
		logic [15:0] f;
		f = fcs ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (f[0]) begin
				f = (f >> 1) ^ FCS_POLY;
			end else begin
				f = f >> 1;
			end
		end
		return f;
	endfunction

endpackage

// File: rtl/adr_ifs.sv
// adr_ifs: channel interfaces of the deframer (line bytes, results, register writes)
// depends on adr_pkg for the register port widths
`timescale 1ns / 1ps

interface adr_line_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       carrier_on;
	modport source (output valid, output rx_byte, output carrier_on, input ready);
	modport sink   (input valid, input rx_byte, input carrier_on, output ready);
endinterface

interface adr_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic        frame_good;
	logic [15:0] frame_length;
	modport source (output valid, output kind, output data_byte, output frame_good,
		output frame_length, input ready);
	modport sink   (input valid, input kind, input data_byte, input frame_good,
		input frame_length, output ready);
endinterface

interface adr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [adr_pkg::CFG_IDX_W-1:0]  index;
	logic [adr_pkg::CFG_DATA_W-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/adr_front.sv
// adr_front: register file and byte classifier; drops ignored and mapped control bytes
// depends on adr_pkg and adr_ifs; feeds classified bytes into the queue
`timescale 1ns / 1ps

module adr_front (
	input  logic              clk,
	input  logic              arst_n,
	adr_line_if.sink          line,
	adr_cfg_if.sink           cfg,
	input  logic              q_ready,
	output logic              q_push,
	output adr_pkg::action_t  q_data
);
	import adr_pkg::*;

	logic        link_enable_q;
	logic [31:0] rx_ctl_map_q;
	logic        flow_enable_q;
	logic [7:0]  stop_char_q;
	logic [7:0]  start_char_q;

	logic accept;
	logic keep;
	logic mapped_ctl;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_enable_q <= 1'b0;
			rx_ctl_map_q  <= 32'hffff_ffff;
			flow_enable_q <= 1'b0;
			stop_char_q   <= 8'd19;
			start_char_q  <= 8'd17;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LINK_ENABLE: link_enable_q <= cfg.wdata[0];
				REG_RX_CTL_MAP:  rx_ctl_map_q  <= cfg.wdata;
				REG_FLOW_ENABLE: flow_enable_q <= cfg.wdata[0];
				REG_STOP_CHAR:   stop_char_q   <= cfg.wdata[7:0];
				REG_START_CHAR:  start_char_q  <= cfg.wdata[7:0];
				default: ;
			endcase
		end
	end

	assign line.ready = q_ready;
	assign accept     = line.valid && q_ready;
	assign mapped_ctl = (line.rx_byte < CTL_LIMIT) && rx_ctl_map_q[line.rx_byte[4:0]];

	always_comb begin
		q_data.data = line.rx_byte;
		q_data.op   = OP_DATA;
		keep        = 1'b1;
		if (line.rx_byte == FLAG_BYTE) begin
			q_data.op = OP_FLAG;
		end else if (line.rx_byte == ESC_BYTE) begin
			q_data.op = OP_ESC;
		end else if (mapped_ctl) begin
			// dropped control byte: only a flow character reaches the back
			if (flow_enable_q && line.rx_byte == stop_char_q) begin
				q_data.op = OP_STOP;
			end else if (flow_enable_q && line.rx_byte == start_char_q) begin
				q_data.op = OP_START;
			end else begin
				keep = 1'b0;
			end
		end
	end

	assign q_push = accept && link_enable_q && line.carrier_on && keep;

endmodule

// File: rtl/adr_queue.sv
// adr_queue: small fifo of classified bytes between front and back
// depends on adr_pkg for the entry type
`timescale 1ns / 1ps

module adr_queue #(
	parameter int DEPTH = adr_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  adr_pkg::action_t  push_data,
	output logic              ready,
	output logic              head_valid,
	output adr_pkg::action_t  head,
	input  logic              pop
);
	import adr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	action_t           mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign ready      = count_q != CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/adr_back.sv
// adr_back: frame state machine, fcs, length, two-byte delay and output register
// depends on adr_pkg and adr_ifs; takes classified bytes from the queue
`timescale 1ns / 1ps

module adr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  adr_pkg::action_t  head,
	output logic              pop,
	adr_result_if.source      result
);
	import adr_pkg::*;

	typedef enum logic [1:0] {
		HUNT_SKIP,
		HUNT_OK,
		HUNT_ESC
	} hunt_t;

	hunt_t       hunt_q;
	logic [15:0] fcs_q;
	logic [15:0] count_q;
	logic [7:0]  held0_q;
	logic [7:0]  held1_q;
	logic        stopped_q;

	logic        res_valid_q;
	kind_t       kind_q;
	logic [7:0]  data_byte_q;
	logic        frame_good_q;
	logic [15:0] frame_length_q;

	logic [7:0]  plain;

	assign pop   = head_valid && (!res_valid_q || result.ready);
	assign plain = (hunt_q == HUNT_ESC) ? (head.data ^ QUOTE_BIT) : head.data;

	assign result.valid        = res_valid_q;
	assign result.kind         = kind_q;
	assign result.data_byte    = data_byte_q;
	assign result.frame_good   = frame_good_q;
	assign result.frame_length = frame_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunt_q         <= HUNT_SKIP;
			fcs_q          <= FCS_INIT;
			count_q        <= '0;
			held0_q        <= '0;
			held1_q        <= '0;
			stopped_q      <= 1'b0;
			res_valid_q    <= 1'b0;
			kind_q         <= KIND_DATA;
			data_byte_q    <= '0;
			frame_good_q   <= 1'b0;
			frame_length_q <= '0;
		end else begin
			if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (pop) begin
				if (head.op == OP_FLAG) begin
					if (count_q != '0) begin
						res_valid_q    <= 1'b1;
						kind_q         <= KIND_END;
						data_byte_q    <= '0;
						frame_good_q   <= (fcs_q == FCS_GOOD) && (hunt_q == HUNT_OK)
							&& (count_q >= 16'd3);
						frame_length_q <= (count_q >= 16'd2) ? count_q - 16'd2 : '0;
					end
					fcs_q   <= FCS_INIT;
					hunt_q  <= HUNT_OK;
					count_q <= '0;
				end else if (hunt_q != HUNT_SKIP) begin
					case (head.op)
						OP_ESC: begin
							// a second escape in a row loses sync
							hunt_q <= (hunt_q == HUNT_OK) ? HUNT_ESC : HUNT_SKIP;
						end
						OP_STOP: begin
							if (!stopped_q) begin
								stopped_q      <= 1'b1;
								res_valid_q    <= 1'b1;
								kind_q         <= KIND_STOP;
								data_byte_q    <= '0;
								frame_good_q   <= 1'b0;
								frame_length_q <= '0;
							end
						end
						OP_START: begin
							if (stopped_q) begin
								stopped_q      <= 1'b0;
								res_valid_q    <= 1'b1;
								kind_q         <= KIND_START;
								data_byte_q    <= '0;
								frame_good_q   <= 1'b0;
								frame_length_q <= '0;
							end
						end
						OP_DATA: begin
							hunt_q <= HUNT_OK;
							fcs_q  <= fcs_update(fcs_q, plain);
							// two bytes held back so the fcs never goes out
							if (count_q >= 16'd2) begin
								res_valid_q    <= 1'b1;
								kind_q         <= KIND_DATA;
								data_byte_q    <= held0_q;
								frame_good_q   <= 1'b0;
								frame_length_q <= '0;
							end
							held0_q <= held1_q;
							held1_q <= plain;
							if (count_q != COUNT_MAX) begin
								count_q <= count_q + 16'd1;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

endmodule

// File: rtl/async_hdlc_rx_deframer.sv
// async_hdlc_rx_deframer: accepts one line byte per cycle when the queue has room.
// a byte goes through the queue and then the output register before its result is valid.
// throughput: one byte per cycle while the result side does not stall, set by the crc/state update in the back.
// a two-entry queue and the output register let line and result sides stall apart.
// reset (arst_n low, asynchronous): registers to defaults, hunting for flag, queue empty.
`timescale 1ns / 1ps

module async_hdlc_rx_deframer #(
	parameter int QUEUE_DEPTH = adr_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	adr_line_if.sink      line,
	adr_cfg_if.sink       cfg,
	adr_result_if.source  result
);
	import adr_pkg::*;

	logic    q_ready;
	logic    q_push;
	action_t q_data;
	logic    head_valid;
	action_t head;
	logic    pop;

	adr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.line    (line),
		.cfg     (cfg),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_data  (q_data)
	);

	adr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_data),
		.ready      (q_ready),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	adr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.result     (result)
	);

endmodule

// File: bench/async_hdlc_rx_deframer_test.sv
// async_hdlc_rx_deframer_test: self-checking bench for the async hdlc receive deframer
// drives line bytes and register writes through the adr_ifs channels, predicts every result
// depends on adr_pkg, adr_ifs and async_hdlc_rx_deframer
`timescale 1ns / 1ps

module async_hdlc_rx_deframer_test;
	import adr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum logic [1:0] {
		HUNT_SKIP,
		HUNT_IN,
		HUNT_ESC
	} hunt_t;

	typedef enum logic [1:0] {
		NOTE_PRED,
		NOTE_NONE,
		NOTE_LIT
	} note_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        good;
		logic [15:0] len;
	} deframe_res_t;

	typedef struct packed {
		logic [7:0]   b;
		logic         car;
		note_t        note;
		deframe_res_t lit;
	} row_t;

	localparam deframe_res_t NO_RES  = '{KIND_DATA, 8'h00, 1'b0, 16'h0000};
	localparam deframe_res_t R_STOP  = '{KIND_STOP, 8'h00, 1'b0, 16'h0000};
	localparam deframe_res_t R_START = '{KIND_START, 8'h00, 1'b0, 16'h0000};
	localparam deframe_res_t R_SHORT = '{KIND_END, 8'h00, 1'b0, 16'h0000};

	// link on, full receive map, flow control on, xoff 0x13, xon 0x11
	row_t script [24] = '{
		'{8'h41, 1'b1, NOTE_NONE, NO_RES},     // hunting, discarded
		'{ESC_BYTE, 1'b1, NOTE_NONE, NO_RES},  // escape while hunting
		'{FLAG_BYTE, 1'b1, NOTE_NONE, NO_RES}, // empty frame
		'{FLAG_BYTE, 1'b1, NOTE_NONE, NO_RES},
		'{8'h13, 1'b1, NOTE_LIT, R_STOP},
		'{8'h13, 1'b1, NOTE_NONE, NO_RES},     // repeated xoff
		'{8'h11, 1'b1, NOTE_LIT, R_START},
		'{8'h11, 1'b1, NOTE_NONE, NO_RES},     // repeated xon
		'{8'hff, 1'b0, NOTE_NONE, NO_RES},     // no carrier
		'{8'h00, 1'b1, NOTE_NONE, NO_RES},     // mapped control dropped
		'{8'h41, 1'b1, NOTE_PRED, NO_RES},
		'{FLAG_BYTE, 1'b1, NOTE_LIT, R_SHORT}, // one byte frame
		'{ESC_BYTE, 1'b1, NOTE_NONE, NO_RES},
		'{8'h1f, 1'b1, NOTE_NONE, NO_RES},     // control keeps escape pending
		'{8'h5e, 1'b1, NOTE_PRED, NO_RES},
		'{8'hff, 1'b1, NOTE_PRED, NO_RES},
		'{8'h20, 1'b1, NOTE_PRED, NO_RES},
		'{8'h80, 1'b1, NOTE_PRED, NO_RES},
		'{FLAG_BYTE, 1'b1, NOTE_PRED, NO_RES},
		'{8'h41, 1'b1, NOTE_PRED, NO_RES},
		'{ESC_BYTE, 1'b1, NOTE_NONE, NO_RES},
		'{ESC_BYTE, 1'b1, NOTE_NONE, NO_RES},  // double escape forces hunt
		'{8'h42, 1'b1, NOTE_NONE, NO_RES},
		'{FLAG_BYTE, 1'b1, NOTE_LIT, R_SHORT}  // aborted frame ends bad
	};

	logic clk;
	logic arst_n;

	adr_line_if   line_bus ();
	adr_cfg_if    cfg_bus ();
	adr_result_if res_bus ();

	async_hdlc_rx_deframer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.line   (line_bus),
		.cfg    (cfg_bus),
		.result (res_bus)
	);

	// predictor state
	logic        link_on   = 1'b0;
	logic [31:0] ctl_map   = 32'hffff_ffff;
	logic        flow_on   = 1'b0;
	logic [7:0]  xoff_char = 8'd19;
	logic [7:0]  xon_char  = 8'd17;
	hunt_t       hunt      = HUNT_SKIP;
	logic [15:0] fcs_acc   = FCS_INIT;
	logic [15:0] run_len   = 16'd0;
	logic [7:0]  held0     = 8'd0;
	logic [7:0]  held1     = 8'd0;
	logic        stopped   = 1'b0;

	deframe_res_t deframe_q [$];
	row_t         line_tag;
	int           mismatches = 0;
	int           bytes_sent = 0;
	bit           quiet      = 1'b0;
	int           hold_ask   = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			fb = c[0] ^ d[k];
			c = c >> 1;
			if (fb) begin
				c = c ^ FCS_POLY;
			end
		end
		return c;
	endfunction

	task automatic deframe_byte(input logic [7:0] b_in, input logic car, output bit hit,
		output deframe_res_t r);
		logic [7:0] b;
		b = b_in;
		hit = 1'b0;
		r = NO_RES;
		if (!link_on || !car) begin
			return;
		end
		if (b == FLAG_BYTE) begin
			if (run_len != 16'd0) begin
				hit = 1'b1;
				r.kind = KIND_END;
				r.good = (fcs_acc == FCS_GOOD) && (hunt == HUNT_IN) && (run_len >= 16'd3);
				r.len = (run_len >= 16'd2) ? run_len - 16'd2 : 16'd0;
			end
			fcs_acc = FCS_INIT;
			hunt = HUNT_IN;
			run_len = 16'd0;
			return;
		end
		if (hunt == HUNT_SKIP) begin
			return;
		end
		if (b == ESC_BYTE) begin
			hunt = (hunt == HUNT_IN) ? HUNT_ESC : HUNT_SKIP;
			return;
		end
		if (b < CTL_LIMIT && ctl_map[b[4:0]]) begin
			if (flow_on) begin
				if (b == xoff_char) begin
					if (!stopped) begin
						stopped = 1'b1;
						hit = 1'b1;
						r.kind = KIND_STOP;
					end
				end else if (b == xon_char) begin
					if (stopped) begin
						stopped = 1'b0;
						hit = 1'b1;
						r.kind = KIND_START;
					end
				end
			end
			return;
		end
		if (hunt == HUNT_ESC) begin
			b = b ^ QUOTE_BIT;
			hunt = HUNT_IN;
		end
		fcs_acc = crc16_step(fcs_acc, b);
		// two bytes of delay keep the fcs bytes from coming out
		if (run_len >= 16'd2) begin
			hit = 1'b1;
			r.kind = KIND_DATA;
			r.data = held0;
		end
		held0 = held1;
		held1 = b;
		if (run_len != COUNT_MAX) begin
			run_len = run_len + 16'd1;
		end
	endtask

	// checker: results, register writes and accepted bytes, sampled at the edge
	always @(posedge clk) begin
		deframe_res_t got;
		deframe_res_t want;
		deframe_res_t r;
		bit           hit;
		if (arst_n) begin
			if (res_bus.valid && res_bus.ready) begin
				got = '{kind_t'(res_bus.kind), res_bus.data_byte, res_bus.frame_good,
					res_bus.frame_length};
				if (deframe_q.size() == 0) begin
					if (mismatches < 10) begin
						$display("%0t: unexpected result kind=%0d data=%02h good=%0d len=%0d",
							$realtime, got.kind, got.data, got.good, got.len);
					end
					mismatches++;
				end else begin
					want = deframe_q.pop_front();
					if (got.kind !== want.kind || got.data !== want.data
						|| got.good !== want.good || got.len !== want.len) begin
						if (mismatches < 10) begin
							$display("%0t: mismatch exp kind=%0d data=%02h good=%0d len=%0d,",
								$realtime, want.kind, want.data, want.good, want.len,
								" got kind=%0d data=%02h good=%0d len=%0d",
								got.kind, got.data, got.good, got.len);
						end
						mismatches++;
					end
				end
			end
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.index)
					REG_LINK_ENABLE: link_on = cfg_bus.wdata[0];
					REG_RX_CTL_MAP:  ctl_map = cfg_bus.wdata;
					REG_FLOW_ENABLE: flow_on = cfg_bus.wdata[0];
					REG_STOP_CHAR:   xoff_char = cfg_bus.wdata[7:0];
					REG_START_CHAR:  xon_char = cfg_bus.wdata[7:0];
					default: ;
				endcase
			end
			if (line_bus.valid && line_bus.ready) begin
				deframe_byte(line_bus.rx_byte, line_bus.carrier_on, hit, r);
				case (line_tag.note)
					NOTE_LIT:  deframe_q.push_back(line_tag.lit);
					NOTE_PRED: if (hit) deframe_q.push_back(r);
					default: ;
				endcase
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		int hold_left;
		hold_left = 0;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask > 0) begin
				hold_left = hold_ask;
				hold_ask = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= quiet || ($urandom_range(99) >= 8);
			end
		end
	end

	task automatic put_row(input row_t r);
		if (!quiet) begin
			while ($urandom_range(99) < 8) begin
				line_bus.valid <= 1'b0;
				@(posedge clk);
			end
		end
		line_bus.valid <= 1'b1;
		line_bus.rx_byte <= r.b;
		line_bus.carrier_on <= r.car;
		line_tag <= r;
		do begin
			@(posedge clk);
		end while (!line_bus.ready);
		bytes_sent++;
	endtask

	task automatic put_byte(input logic [7:0] b, input logic car);
		put_row('{b, car, NOTE_PRED, NO_RES});
	endtask

	task automatic put_stuffed(input logic [7:0] b);
		if (b == FLAG_BYTE || b == ESC_BYTE || (b < CTL_LIMIT && ctl_map[b[4:0]])) begin
			put_byte(ESC_BYTE, 1'b1);
			put_byte(b ^ QUOTE_BIT, 1'b1);
		end else begin
			put_byte(b, 1'b1);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.wdata <= data;
		do begin
			@(posedge clk);
		end while (!cfg_bus.ready);
	endtask

	task automatic set_regs(input logic link, input logic [31:0] map, input logic flow,
		input logic [7:0] xoff, input logic [7:0] xon);
		write_reg(REG_LINK_ENABLE, {31'd0, link});
		write_reg(REG_RX_CTL_MAP, map);
		write_reg(REG_FLOW_ENABLE, {31'd0, flow});
		write_reg(REG_STOP_CHAR, {24'd0, xoff});
		write_reg(REG_START_CHAR, {24'd0, xon});
		cfg_bus.valid <= 1'b0;
	endtask

	// pause the line until every expected result is out, then let the pipeline drain
	task automatic settle();
		line_bus.valid <= 1'b0;
		while (deframe_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic send_frame();
		logic [7:0]  body [$];
		logic [15:0] f;
		logic [7:0]  b;
		int          n;
		int          flaw;
		int          mid;
		n = ($urandom_range(19) == 0) ? $urandom_range(60) : $urandom_range(10);
		f = FCS_INIT;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(255));
			body.push_back(b);
			f = crc16_step(f, b);
		end
		f = ~f;
		body.push_back(f[7:0]);
		body.push_back(f[15:8]);
		flaw = $urandom_range(99);
		mid = $urandom_range(body.size() - 1);
		if (flaw < 8) begin
			body[mid] = body[mid] ^ (8'd1 << $urandom_range(7));
		end else if (flaw < 12) begin
			void'(body.pop_back());
		end
		if ($urandom_range(9) < 3) begin
			put_byte(FLAG_BYTE, 1'b1);
		end
		for (int i = 0; i < body.size(); i++) begin
			if ($urandom_range(99) < 4) begin
				// control noise, biased toward the flow characters
				case ($urandom_range(3))
					0: put_byte(xoff_char, 1'b1);
					1: put_byte(xon_char, 1'b1);
					default: put_byte(8'($urandom_range(31)), 1'b1);
				endcase
			end
			if ($urandom_range(99) < 3) begin
				put_byte(8'($urandom_range(255)), 1'b0);
			end
			if (flaw >= 12 && flaw < 15 && i == mid) begin
				put_byte(ESC_BYTE, 1'b1);
				put_byte(ESC_BYTE, 1'b1);
			end
			put_stuffed(body[i]);
		end
		if ($urandom_range(19) == 0) begin
			put_byte(ESC_BYTE, 1'b1);
		end
		put_byte(FLAG_BYTE, 1'b1);
	endtask

	task automatic run_traffic(input int count, input bit with_hold);
		int start;
		int frames;
		start = bytes_sent;
		frames = 0;
		while (bytes_sent - start < count) begin
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 8)) begin
					put_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
				end
			end else begin
				send_frame();
			end
			frames++;
			if (with_hold && frames == 6) begin
				hold_ask = 400;
			end
		end
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		line_bus.valid <= 1'b0;
		line_bus.rx_byte <= 8'h00;
		line_bus.carrier_on <= 1'b0;
		line_tag <= '{8'h00, 1'b0, NOTE_NONE, NO_RES};
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_LINK_ENABLE;
		cfg_bus.wdata <= 32'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// link is down after reset
		put_row('{8'h41, 1'b1, NOTE_NONE, NO_RES});
		put_row('{FLAG_BYTE, 1'b1, NOTE_NONE, NO_RES});
		settle();

		set_regs(1'b1, 32'hffff_ffff, 1'b1, 8'h13, 8'h11);
		foreach (script[i]) begin
			put_row(script[i]);
		end
		settle();

		quiet = 1'b1;
		run_traffic(260, 1'b1);
		settle();
		quiet = 1'b0;

		set_regs(1'b1, 32'h0000_0000, 1'b0, 8'h00, 8'h1f);
		run_traffic(250, 1'b0);
		settle();

		set_regs(1'b1, $urandom, 1'b1, 8'hff, 8'hff);
		run_traffic(250, 1'b0);
		settle();

		set_regs(1'b1, $urandom | 32'h000a_0000, 1'b1, 8'($urandom_range(31)),
			8'($urandom_range(31)));
		run_traffic(250, 1'b0);
		settle();

		set_regs(1'b0, 32'hffff_ffff, 1'b1, 8'h13, 8'h11);
		@(posedge clk);
		write_reg(REG_UNUSED, 32'hffff_ffff);
		cfg_bus.valid <= 1'b0;
		repeat (30) put_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
		settle();

		set_regs(1'b1, 32'hffff_ffff, 1'b1, 8'h00, 8'h1f);
		run_traffic(250, 1'b0);
		settle();

		set_regs(1'b1, 32'hffff_ffff, 1'b0, 8'h13, 8'h11);
		run_traffic(100, 1'b0);

		line_bus.valid <= 1'b0;
		waited = 0;
		while (deframe_q.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (deframe_q.size() != 0) begin
			$display("%0d expected results never arrived", deframe_q.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout");
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
